// ----- src/bcc_pkg.sv -----
// Shared types, constants and helper functions of the belt centering controller.
// No dependencies; every other file imports this package.
package bcc_pkg;

  localparam int TIME_W   = 32;   // millisecond time base width
  localparam int JOY_W    = 12;   // joystick reading width
  localparam int DELTA_W  = 7;
  localparam int MDUR_W   = 16;
  localparam int RINT_W   = 20;
  localparam int DRV_W    = 8;
  localparam int CNT_W    = 16;
  localparam int MODE_W   = 2;
  localparam int DIR_W    = 2;

  localparam int DIVD_W   = TIME_W + MDUR_W;   // dividend of the ratio divider
  localparam int DVSR_W   = TIME_W;            // divisor of the ratio divider
  localparam int DCNT_W   = $clog2(DIVD_W + 1);
  localparam int JRCP_W   = 29;                // joystick reciprocal width
  localparam int JPROD_W  = JOY_W + JRCP_W;    // (level - low) * reciprocal
  localparam int JOY_SHIFT = 32;
  localparam int JQ_W     = 9;                 // joystick quotient, at most 277

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  localparam logic [JOY_W-1:0]  JOY_LOW  = JOY_W'(287);
  // 255 * ceil(2^32 / 3500): (x * JOY_RECIP) >> 32 equals x * 255 / 3500
  // exactly for every offset reading of the 12-bit range
  localparam logic [JRCP_W-1:0] JOY_RECIP = JRCP_W'(312919170);
  localparam logic [JQ_W-1:0]   DEAD_LO  = JQ_W'(121);
  localparam logic [JQ_W-1:0]   DEAD_HI  = JQ_W'(133);
  localparam logic [JQ_W-1:0]   DRV_MAX  = JQ_W'(255);
  localparam logic [DRV_W-1:0]  NEUTRAL  = DRV_W'(127);

  localparam logic [DELTA_W-1:0] DELTA_RST = DELTA_W'(63);
  localparam logic [MDUR_W-1:0]  MDUR_RST  = MDUR_W'(500);
  localparam logic [RINT_W-1:0]  RINT_RST  = RINT_W'(60000);

  localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
  localparam logic [DIR_W-1:0] DIR_POS  = 2'b01;
  localparam logic [DIR_W-1:0] DIR_NEG  = 2'b11;

  typedef enum logic [MODE_W-1:0] {
    MODE_MANUAL   = 2'd0,
    MODE_CENTERED = 2'd1,
    MODE_OFF      = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_DELTA = 2'd0,
    REG_MDUR  = 2'd1,
    REG_RINT  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic [MDUR_W-1:0]  mdur;
    logic [RINT_W-1:0]  rint;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input transfer
    logic entry;       // entry actions and repeat check
    logic div_start;   // launch ratio divider
    logic finish;      // move-end test, exits, result write
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_needed;
    logic div_done;
    logic out_free;
  } dp_stat_t;

  // 127 + dir * delta, dir in -1..1; neg flips the direction
  function automatic logic [DRV_W-1:0] drive_level(input logic [DIR_W-1:0]   dir,
                                                    input logic               neg,
                                                    input logic [DELTA_W-1:0] delta);
    logic [DIR_W-1:0] d;
    d = neg ? (~dir + DIR_POS) : dir;
    if (d == DIR_POS) begin
      return NEUTRAL + DRV_W'(delta);
    end else if (d == DIR_NEG) begin
      return NEUTRAL - DRV_W'(delta);
    end else begin
      return NEUTRAL;
    end
  endfunction

  // deadband around neutral, then clamp to 0..255 (negative already mapped to 0)
  function automatic logic [DRV_W-1:0] joy_map(input logic [JQ_W-1:0] t);
    if (t > DEAD_LO && t < DEAD_HI) begin
      return NEUTRAL;
    end else if (t > DRV_MAX) begin
      return DRV_MAX[DRV_W-1:0];
    end else begin
      return t[DRV_W-1:0];
    end
  endfunction

endpackage

// ----- src/belt_centering_controller.sv -----
// Belt centering controller: one input transfer per millisecond tick, one result each.
//
// Input stream (in_*): buttons, edge sensors, belt-running flag and the averaged
// joystick reading of one tick. Output stream (out_*): steering and tension drive
// levels, current mode and the correction count after that tick.
// Config port (cfg_*): delta_offset at 0x0, move_duration at 0x4,
// repeat_interval at 0x8; write only while no tick is in flight.
// Sequence: an accepted tick passes through the entry, load and finish steps to its
// result transfer; the first tick in centered mode with a ratio move also runs the
// 48-step divider before its finish step. One tick is processed at a time.
// Reset: manual mode, drives at 127, timers and counters cleared, config
// registers at their defaults.
// A finished result waits in the output register; the next tick may be accepted
// meanwhile, and it stalls at its finish step until the register is taken.
// Depends on bcc_pkg, bcc_cfg, bcc_ctrl, bcc_dp, bcc_div.
module belt_centering_controller
  import bcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [0] manual_select, [1] tension_select, [2] inner_sensor, [3] outer_sensor,
  // [4] belt_running, [16:5] joystick_level, [23:17] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] steer_drive, [15:8] tension_drive, [17:16] mode_state,
  // [33:18] corrections_done, [39:34] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  bcc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bcc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- src/bcc_cfg.sv -----
// Configuration register file with an APB-style slave port.
// Depends on bcc_pkg.
module bcc_cfg
  import bcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  logic [DELTA_W-1:0] delta_r;
  logic [MDUR_W-1:0]  mdur_r;
  logic [RINT_W-1:0]  rint_r;
  reg_idx_t           idx;
  logic               wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r <= DELTA_RST;
      mdur_r  <= MDUR_RST;
      rint_r  <= RINT_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_DELTA: delta_r <= cfg_pwdata[DELTA_W-1:0];
        REG_MDUR:  mdur_r  <= cfg_pwdata[MDUR_W-1:0];
        REG_RINT:  rint_r  <= cfg_pwdata[RINT_W-1:0];
        default:   ;   // unmapped slot, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DELTA: cfg_prdata = CFG_DW'(delta_r);
      REG_MDUR:  cfg_prdata = CFG_DW'(mdur_r);
      REG_RINT:  cfg_prdata = CFG_DW'(rint_r);
      default:   cfg_prdata = '0;
    endcase
  end

  assign cfg.delta = delta_r;
  assign cfg.mdur  = mdur_r;
  assign cfg.rint  = rint_r;

endmodule

// ----- src/bcc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bcc_pkg. Divisor must be nonzero.
module bcc_div
  import bcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DVSR_W-1:0] divisor,
  output logic [DIVD_W-1:0] quotient,
  output logic              done
);

  logic [DIVD_W-1:0] quo_r;
  logic [DVSR_W-1:0] rem_r, rem_nxt, dvsr_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r, done_r;
  logic [DVSR_W:0]   trial, diff;
  logic              ge;

  assign trial   = {rem_r, quo_r[DIVD_W-1]};
  assign diff    = trial - {1'b0, dvsr_r};
  assign ge      = trial >= {1'b0, dvsr_r};
  assign rem_nxt = ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_W'(DIVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DCNT_W'(1);
        if (cnt_r == DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r  <= dividend;
      rem_r  <= '0;
      dvsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVD_W-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ----- src/bcc_dp.sv -----
// Datapath: mode and timing registers, entry actions, joystick mapping,
// ratio move, exit logic and the output register. Depends on bcc_pkg, bcc_div.
module bcc_dp
  import bcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cfg_t                   cfg,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // captured input transfer
  logic             man_r, ten_r, inner_r, outer_r, run_r;
  logic [JOY_W-1:0] joy_r;

  // controller state
  mode_t             mode_r, mode_nxt;
  logic              first_r;
  logic [TIME_W-1:0] now_r, last_center_r, last_out_r, last_pass_r;
  logic [TIME_W-1:0] tto_r, ttc_r, move_end_r;
  logic [DIR_W-1:0]  dir_r, dir_entry;
  logic [CNT_W-1:0]  cc_r, cc_bump;
  logic [DRV_W-1:0]  steer_r, tension_r;

  // output register
  logic              out_valid_r;
  logic [DRV_W-1:0]  out_steer_r, out_tension_r;
  logic [MODE_W-1:0] out_mode_r;
  logic [CNT_W-1:0]  out_cc_r;

  logic                use_ratio;
  logic [JOY_W-1:0]    joy_diff;
  logic [JPROD_W-1:0]  joy_prod;
  logic [JQ_W-1:0]     joy_q;
  logic [DIVD_W-1:0]   ratio_dvd, quo;
  logic                div_done;
  logic [TIME_W-1:0]   elapsed_pass, ratio_len, me_fin;
  logic [2*MDUR_W-1:0] cent_len;
  logic                repeat_due, halt, change;
  logic [DRV_W-1:0]    joy_lvl, st_fin, te_fin;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      man_r   <= in_tdata[0];
      ten_r   <= in_tdata[1];
      inner_r <= in_tdata[2];
      outer_r <= in_tdata[3];
      run_r   <= in_tdata[4];
      joy_r   <= in_tdata[5 +: JOY_W];
    end
  end

  assign use_ratio   = (mode_r == MODE_CENTERED) && first_r &&
                       (tto_r != '0) && (ttc_r != '0);

  // joystick scaling by reciprocal multiply; below range maps to 0
  assign joy_diff  = (joy_r >= JOY_LOW) ? (joy_r - JOY_LOW) : '0;
  assign joy_prod  = JPROD_W'(joy_diff) * JPROD_W'(JOY_RECIP);
  assign joy_q     = joy_prod[JOY_SHIFT +: JQ_W];

  // divider operands: the time ratio move
  assign ratio_dvd = DIVD_W'(ttc_r) * DIVD_W'(cfg.mdur);

  bcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (ratio_dvd),
    .divisor  (tto_r),
    .quotient (quo),
    .done     (div_done)
  );

  assign stat.div_needed = use_ratio;
  assign stat.div_done   = div_done;
  assign stat.out_free   = !out_valid_r || out_tready;

  // entry-cycle terms
  assign elapsed_pass = now_r - last_pass_r;
  assign repeat_due   = elapsed_pass > TIME_W'(cfg.rint);
  assign cent_len     = (2*MDUR_W)'(cfg.mdur) * (2*MDUR_W)'(cc_r);
  assign cc_bump      = (cc_r == '1) ? cc_r : cc_r + CNT_W'(1);

  always_comb begin
    if (!inner_r && !outer_r) begin
      dir_entry = DIR_POS;
    end else if (inner_r && outer_r) begin
      dir_entry = DIR_NEG;
    end else begin
      dir_entry = dir_r;   // mixed sensors keep the old direction
    end
  end

  // finish-cycle terms
  assign ratio_len = (|quo[DIVD_W-1:TIME_W]) ? '1 : quo[TIME_W-1:0];
  assign joy_lvl   = joy_map(joy_q);

  always_comb begin
    halt     = 1'b0;
    st_fin   = steer_r;
    te_fin   = tension_r;
    me_fin   = move_end_r;
    mode_nxt = mode_r;
    unique case (mode_r)
      MODE_CENTERED: begin
        if (use_ratio) begin
          me_fin = now_r + ratio_len;
          st_fin = drive_level(dir_r, 1'b0, cfg.delta);
        end
        halt = now_r >= me_fin;
        if (man_r) begin
          mode_nxt = MODE_MANUAL;
        end else if (run_r && (!inner_r || outer_r)) begin
          mode_nxt = MODE_OFF;
        end
      end
      MODE_OFF: begin
        halt = now_r >= move_end_r;
        if (man_r) begin
          mode_nxt = MODE_MANUAL;
        end else if (!run_r || (inner_r && !outer_r)) begin
          mode_nxt = MODE_CENTERED;
        end
      end
      default: begin
        if (man_r) begin
          if (ten_r) begin
            st_fin = NEUTRAL;
            te_fin = joy_lvl;
          end else begin
            st_fin = joy_lvl;
            te_fin = NEUTRAL;
          end
        end else begin
          mode_nxt = MODE_CENTERED;
        end
      end
    endcase
    change = mode_nxt != mode_r;
    if (halt || change) begin
      st_fin = NEUTRAL;
      te_fin = NEUTRAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_MANUAL;
      first_r       <= 1'b1;
      now_r         <= '0;
      last_center_r <= '0;
      last_out_r    <= '0;
      last_pass_r   <= '0;
      tto_r         <= '0;
      ttc_r         <= '0;
      move_end_r    <= '0;
      dir_r         <= DIR_NONE;
      cc_r          <= '0;
      steer_r       <= NEUTRAL;
      tension_r     <= NEUTRAL;
    end else begin
      if (cmd.entry) begin
        unique case (mode_r)
          MODE_CENTERED: begin
            if (first_r) begin
              last_center_r <= now_r;
              if (last_out_r != '0) begin
                ttc_r <= now_r - last_out_r;
              end
              // undo the accumulated moves
              steer_r    <= drive_level(dir_r, 1'b1, cfg.delta);
              move_end_r <= now_r + TIME_W'(cent_len);
            end
          end
          MODE_OFF: begin
            if (first_r) begin
              cc_r          <= CNT_W'(1);
              last_out_r    <= now_r;
              last_pass_r   <= now_r;
              tto_r         <= now_r - last_center_r;
              dir_r         <= dir_entry;
              steer_r       <= drive_level(dir_entry, 1'b0, cfg.delta);
              move_end_r    <= now_r + TIME_W'(cfg.mdur);
            end else if (repeat_due) begin
              cc_r        <= cc_bump;
              steer_r     <= drive_level(dir_r, 1'b0, cfg.delta);
              move_end_r  <= now_r + TIME_W'(cfg.mdur);
              last_pass_r <= now_r;
            end
          end
          default: begin
            if (first_r) begin
              last_out_r    <= '0;
              last_center_r <= '0;
              ttc_r         <= '0;
              tto_r         <= '0;
              cc_r          <= '0;
              steer_r       <= NEUTRAL;
              tension_r     <= NEUTRAL;
            end
          end
        endcase
      end
      if (cmd.finish) begin
        steer_r    <= st_fin;
        tension_r  <= te_fin;
        move_end_r <= me_fin;
        mode_r     <= mode_nxt;
        first_r    <= change;
        now_r      <= now_r + TIME_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_steer_r   <= st_fin;
      out_tension_r <= te_fin;
      out_mode_r    <= mode_nxt;
      out_cc_r      <= cc_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - 2*DRV_W - MODE_W - CNT_W)'(0),
                       out_cc_r, out_mode_r, out_tension_r, out_steer_r};

endmodule

// ----- src/bcc_ctrl.sv -----
// Sequencing state machine: accept, entry actions, divider launch and wait,
// finish. Depends on bcc_pkg.
module bcc_ctrl
  import bcc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ENTRY  = 5'b00010,
    S_LOAD   = 5'b00100,
    S_DIV    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    unique case (state_r)
      S_IDLE:   state_nxt = in_tvalid ? S_ENTRY : S_IDLE;
      S_ENTRY:  state_nxt = S_LOAD;
      S_LOAD:   state_nxt = stat.div_needed ? S_DIV : S_FINISH;
      S_DIV:    state_nxt = stat.div_done ? S_FINISH : S_DIV;
      S_FINISH: state_nxt = stat.out_free ? S_IDLE : S_FINISH;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready     = state_r == S_IDLE;
  assign cmd.load      = in_tvalid && (state_r == S_IDLE);
  assign cmd.entry     = state_r == S_ENTRY;
  assign cmd.div_start = (state_r == S_LOAD) && stat.div_needed;
  assign cmd.finish    = (state_r == S_FINISH) && stat.out_free;

endmodule
